@@ hdl/acfd_pkg.sv @@
// acfd_pkg: shared constants and types for the ir frame decoder
// holds header bytes, decode codes and the frame state struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acfd_pkg;

   // frame layout
   localparam logic [3:0] FRAME_LEN   = 4'd13;
   localparam logic [3:0] POS_HDR0    = 4'd0;
   localparam logic [3:0] POS_HDR1    = 4'd1;
   localparam logic [3:0] POS_HDR2    = 4'd2;
   localparam logic [3:0] POS_TEMP    = 4'd4;
   localparam logic [3:0] POS_POWER   = 4'd5;
   localparam logic [3:0] POS_MODEFAN = 4'd6;
   localparam logic [3:0] POS_SUM     = 4'd12;

   // header bytes
   localparam logic [7:0] HDR0 = 8'hAA;
   localparam logic [7:0] HDR1 = 8'h5A;
   localparam logic [7:0] HDR2 = 8'hCF;

   // power byte values
   localparam logic [7:0] PWR_OFF_BYTE = 8'h21;
   localparam logic [7:0] PWR_ON_BYTE  = 8'h31;

   // mode nibble values (low nibble of byte 6)
   localparam logic [3:0] MODE_NIB_HEAT = 4'h1;
   localparam logic [3:0] MODE_NIB_COOL = 4'h2;
   localparam logic [3:0] MODE_NIB_DRY  = 4'h3;

   // fan nibble values (high nibble of byte 6)
   localparam logic [3:0] FAN_NIB_AUTO = 4'h2;
   localparam logic [3:0] FAN_NIB_S1   = 4'h3;
   localparam logic [3:0] FAN_NIB_S2   = 4'h5;
   localparam logic [3:0] FAN_NIB_S3   = 4'h7;

   // temperature
   localparam logic [8:0] TEMP_OFFSET  = 9'd17;
   localparam logic [8:0] TEMP_DEFAULT = 9'd10;

   // result codes
   localparam logic [1:0] POWER_UNKNOWN = 2'd0;
   localparam logic [1:0] POWER_OFF     = 2'd1;
   localparam logic [1:0] POWER_ON      = 2'd2;

   localparam logic [2:0] MODE_UNKNOWN    = 3'd0;
   localparam logic [2:0] MODE_HEAT       = 3'd1;
   localparam logic [2:0] MODE_MAINT_HEAT = 3'd2;
   localparam logic [2:0] MODE_COOL       = 3'd3;
   localparam logic [2:0] MODE_DRY        = 3'd4;

   localparam logic [2:0] FAN_UNKNOWN = 3'd0;
   localparam logic [2:0] FAN_AUTO    = 3'd1;
   localparam logic [2:0] FAN_SPEED1  = 3'd2;
   localparam logic [2:0] FAN_SPEED2  = 3'd3;
   localparam logic [2:0] FAN_SPEED3  = 3'd4;

   // running state of the frame being received
   typedef struct packed {
      logic [3:0] byte_index;
      logic       header_ok;
      logic [7:0] xor_acc;
      logic [7:0] temp_byte;
      logic [7:0] power_byte;
      logic [7:0] mode_fan_byte;
   } frame_state_type;

   // one decoded result
   typedef struct packed {
      logic       sum_ok;
      logic [3:0] received_sum;
      logic [3:0] computed_sum;
      logic [2:0] fan_speed;
      logic [8:0] temperature;
      logic [2:0] op_mode;
      logic [1:0] power_state;
      logic       is_match;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_DATA_BITS = 32;

endpackage

`default_nettype wire

@@ hdl/acfd_frame_track.sv @@
// acfd_frame_track: per-frame state registers of the ir frame decoder
// counts bytes, checks header, accumulates xor, keeps bytes 4 to 6
// depends on acfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module acfd_frame_track (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      byte_accept,
   input  wire logic [7:0]                frame_byte,
   input  wire logic                      last_byte,
   output acfd_pkg::frame_state_type      state
);

   acfd_pkg::frame_state_type state_ff;
   acfd_pkg::frame_state_type state_in;

   // next state for one accepted byte
   always_comb begin
      state_in = state_ff;
      if (byte_accept) begin
         if ((state_ff.byte_index == acfd_pkg::POS_HDR0 && frame_byte != acfd_pkg::HDR0) ||
             (state_ff.byte_index == acfd_pkg::POS_HDR1 && frame_byte != acfd_pkg::HDR1) ||
             (state_ff.byte_index == acfd_pkg::POS_HDR2 && frame_byte != acfd_pkg::HDR2)) begin
            state_in.header_ok = 1'b0;
         end
         if (state_ff.byte_index < acfd_pkg::POS_SUM) begin
            state_in.xor_acc = state_ff.xor_acc ^ frame_byte;
         end
         if (state_ff.byte_index == acfd_pkg::POS_TEMP) begin
            state_in.temp_byte = frame_byte;
         end
         if (state_ff.byte_index == acfd_pkg::POS_POWER) begin
            state_in.power_byte = frame_byte;
         end
         if (state_ff.byte_index == acfd_pkg::POS_MODEFAN) begin
            state_in.mode_fan_byte = frame_byte;
         end
         // saturate so over-long frames never match
         if (state_ff.byte_index < acfd_pkg::FRAME_LEN) begin
            state_in.byte_index = state_ff.byte_index + 4'd1;
         end
         // final byte starts a fresh frame
         if (last_byte) begin
            state_in = '{byte_index: 4'd0, header_ok: 1'b1, xor_acc: 8'd0,
                         temp_byte: 8'd0, power_byte: 8'd0, mode_fan_byte: 8'd0};
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{byte_index: 4'd0, header_ok: 1'b1, xor_acc: 8'd0,
                       temp_byte: 8'd0, power_byte: 8'd0, mode_fan_byte: 8'd0};
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

@@ hdl/acfd_decode.sv @@
// acfd_decode: decodes the final byte and the frame state into one result
// pure combinational; all fields are zero when the frame does not match
// depends on acfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module acfd_decode (
   input  wire acfd_pkg::frame_state_type state,
   input  wire logic [7:0]                frame_byte,
   output acfd_pkg::result_type           result
);

   logic [7:0] sum_byte;
   logic [3:0] sum_nib;
   logic [3:0] mode_nib;
   logic [3:0] fan_nib;
   logic       temp_zero;
   logic       frame_ok;

   assign sum_byte  = state.xor_acc ^ {4'h0, frame_byte[3:0]};
   assign sum_nib   = sum_byte[7:4] ^ sum_byte[3:0];
   assign mode_nib  = state.mode_fan_byte[3:0];
   assign fan_nib   = state.mode_fan_byte[7:4];
   assign temp_zero = (state.temp_byte == 8'd0);
   assign frame_ok  = (state.byte_index == acfd_pkg::POS_SUM) && state.header_ok;

   always_comb begin
      result = '0;
      if (frame_ok) begin
         result.is_match = 1'b1;

         // power
         if (state.power_byte == acfd_pkg::PWR_OFF_BYTE) begin
            result.power_state = acfd_pkg::POWER_OFF;
         end else if (state.power_byte == acfd_pkg::PWR_ON_BYTE) begin
            result.power_state = acfd_pkg::POWER_ON;
         end else begin
            result.power_state = acfd_pkg::POWER_UNKNOWN;
         end

         // mode, heat becomes maintenance heat when temperature byte is zero
         case (mode_nib)
            acfd_pkg::MODE_NIB_HEAT: begin
               result.op_mode = temp_zero ? acfd_pkg::MODE_MAINT_HEAT : acfd_pkg::MODE_HEAT;
            end
            acfd_pkg::MODE_NIB_COOL: result.op_mode = acfd_pkg::MODE_COOL;
            acfd_pkg::MODE_NIB_DRY:  result.op_mode = acfd_pkg::MODE_DRY;
            default:                 result.op_mode = acfd_pkg::MODE_UNKNOWN;
         endcase

         // temperature
         result.temperature = temp_zero ? acfd_pkg::TEMP_DEFAULT
                                        : {1'b0, state.temp_byte} + acfd_pkg::TEMP_OFFSET;

         // fan
         case (fan_nib)
            acfd_pkg::FAN_NIB_AUTO: result.fan_speed = acfd_pkg::FAN_AUTO;
            acfd_pkg::FAN_NIB_S1:   result.fan_speed = acfd_pkg::FAN_SPEED1;
            acfd_pkg::FAN_NIB_S2:   result.fan_speed = acfd_pkg::FAN_SPEED2;
            acfd_pkg::FAN_NIB_S3:   result.fan_speed = acfd_pkg::FAN_SPEED3;
            default:                result.fan_speed = acfd_pkg::FAN_UNKNOWN;
         endcase

         // checksum
         result.computed_sum = sum_nib;
         result.received_sum = frame_byte[7:4];
         result.sum_ok       = (sum_nib == frame_byte[7:4]);
      end
   end

endmodule

`default_nettype wire

@@ hdl/ac_ir_frame_decoder_unit.sv @@
// ac_ir_frame_decoder_unit: top level of the ir air-conditioner frame decoder
// instantiates acfd_frame_track and acfd_decode, holds the result register
// depends on acfd_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one received frame byte per transfer on the req stream, with tlast on
// the final byte, and gives one result transfer on the rsp stream for every
// final byte. A byte is taken in every cycle in which req_tready is high; the
// result of a final byte is registered and appears on rsp in the cycle after
// its transfer. req_tready is low only while a result waits in the output
// register and rsp_tready is low. A frame matches when it is exactly 13 bytes
// and starts AA 5A CF; otherwise every result field is zero. State returns to
// its reset values after every final byte.
module ac_ir_frame_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // req stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire logic        req_tlast,   // last_byte
   // rsp stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // [0] is_match, [2:1] power_state,
                                         // [5:3] op_mode, [14:6] temperature,
                                         // [17:15] fan_speed, [21:18] computed_sum,
                                         // [25:22] received_sum, [26] sum_ok
);

   acfd_pkg::frame_state_type frame_state;
   acfd_pkg::result_type      result;
   acfd_pkg::result_type      rsp_data_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      req_accept;

   // input transfer
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   acfd_frame_track u_track (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .frame_byte  (req_tdata),
      .last_byte   (req_tlast),
      .state       (frame_state)
   );

   acfd_decode u_decode (
      .state      (frame_state),
      .frame_byte (req_tdata),
      .result     (result)
   );

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(acfd_pkg::RSP_DATA_BITS - acfd_pkg::RESULT_BITS){1'b0}},
                        rsp_data_ff};

`ifndef SYNTHESIS
   // a final byte always leaves a result pending
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid)
      else $error("final byte transfer did not produce a result");

   // a non-final byte never creates a result
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_tlast && (!rsp_valid_ff || rsp_tready) |=> !rsp_tvalid)
      else $error("result appeared without a final byte");

   // a mismatched frame has all fields zero
   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[26:1] == 26'd0)
      else $error("mismatched frame carries nonzero fields");

   // frame state restarts after a final byte
   a_state_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> frame_state.byte_index == 4'd0 && frame_state.header_ok)
      else $error("frame state not cleared after final byte");

   // byte index saturates at frame length
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      frame_state.byte_index <= acfd_pkg::FRAME_LEN)
      else $error("byte index beyond saturation");
`endif

endmodule

`default_nettype wire

@@ tb/sv/ac_ir_frame_decoder_unit_tb.sv @@
// ac_ir_frame_decoder_unit_tb: self-checking testbench for the ir frame decoder
// streams frame bytes on req, predicts each decoded result and checks rsp
// depends on acfd_pkg and ac_ir_frame_decoder_unit
`timescale 1ns / 1ps
`default_nettype none

module ac_ir_frame_decoder_unit_tb
   import acfd_pkg::*;
();

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 2;
   localparam int BYTE_TARGET  = 1950;
   localparam int IDLE_PCT     = 14;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int LIMIT_CYCLES = 400000;
   localparam int REPORT_MAX   = 10;

   // decoded-frame predictor and the queue of results it still owes
   class frame_scoreboard;
      frame_state_type st;
      result_type      owed[$];
      int              errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         st.byte_index    = '0;
         st.header_ok     = 1'b1;
         st.xor_acc       = '0;
         st.temp_byte     = '0;
         st.power_byte    = '0;
         st.mode_fan_byte = '0;
      endfunction

      // update the running frame state with one accepted byte; a final byte queues its result
      function void note_byte(logic [7:0] b, logic last);
         logic [3:0] pos;
         logic [7:0] acc;
         logic [3:0] fold;
         result_type r;
         pos = st.byte_index;
         if (pos == POS_HDR0 && b != HDR0) st.header_ok = 1'b0;
         if (pos == POS_HDR1 && b != HDR1) st.header_ok = 1'b0;
         if (pos == POS_HDR2 && b != HDR2) st.header_ok = 1'b0;
         if (pos < POS_SUM) st.xor_acc = st.xor_acc ^ b;
         if (pos == POS_TEMP) st.temp_byte = b;
         if (pos == POS_POWER) st.power_byte = b;
         if (pos == POS_MODEFAN) st.mode_fan_byte = b;
         if (st.byte_index < FRAME_LEN) st.byte_index = st.byte_index + 4'd1;
         if (!last) return;

         // a frame that does not match leaves every field at zero
         r = '0;
         if (pos == POS_SUM && st.header_ok) begin
            acc  = st.xor_acc ^ {4'h0, b[3:0]};
            fold = acc[7:4] ^ acc[3:0];
            r.is_match = 1'b1;
            if (st.power_byte == PWR_OFF_BYTE) r.power_state = POWER_OFF;
            else if (st.power_byte == PWR_ON_BYTE) r.power_state = POWER_ON;
            else r.power_state = POWER_UNKNOWN;
            case (st.mode_fan_byte[3:0])
               MODE_NIB_HEAT: begin
                  r.op_mode = (st.temp_byte == 8'd0) ? MODE_MAINT_HEAT : MODE_HEAT;
               end
               MODE_NIB_COOL: r.op_mode = MODE_COOL;
               MODE_NIB_DRY:  r.op_mode = MODE_DRY;
               default:       r.op_mode = MODE_UNKNOWN;
            endcase
            r.temperature = (st.temp_byte == 8'd0) ? TEMP_DEFAULT
                                                   : {1'b0, st.temp_byte} + TEMP_OFFSET;
            case (st.mode_fan_byte[7:4])
               FAN_NIB_AUTO: r.fan_speed = FAN_AUTO;
               FAN_NIB_S1:   r.fan_speed = FAN_SPEED1;
               FAN_NIB_S2:   r.fan_speed = FAN_SPEED2;
               FAN_NIB_S3:   r.fan_speed = FAN_SPEED3;
               default:      r.fan_speed = FAN_UNKNOWN;
            endcase
            r.computed_sum = fold;
            r.received_sum = b[7:4];
            r.sum_ok       = (fold == b[7:4]);
         end
         owed.push_back(r);
         clear();
      endfunction

      // compare one accepted result transfer with the oldest owed result
      function void check_result(logic [31:0] d);
         result_type e;
         result_type a;
         logic [31-RESULT_BITS:0] pad;
         bit bad;
         a   = result_type'(d[RESULT_BITS-1:0]);
         pad = d[31:RESULT_BITS];
         if (owed.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("[%0t] unexpected result transfer, tdata=%h", $realtime, d);
            return;
         end
         e   = owed.pop_front();
         bad = (a.is_match != e.is_match) || (a.power_state != e.power_state) ||
               (a.op_mode != e.op_mode) || (a.temperature != e.temperature) ||
               (a.fan_speed != e.fan_speed) || (a.computed_sum != e.computed_sum) ||
               (a.received_sum != e.received_sum) || (a.sum_ok != e.sum_ok) ||
               (pad != '0);
         if (bad) begin
            errors++;
            if (errors <= REPORT_MAX) begin
               $display("[%0t] result mismatch", $realtime);
               $display("   exp: match=%0d pwr=%0d mode=%0d temp=%0d fan=%0d csum=%h rsum=%h ok=%0d",
                        e.is_match, e.power_state, e.op_mode, e.temperature,
                        e.fan_speed, e.computed_sum, e.received_sum, e.sum_ok);
               $display("   got: match=%0d pwr=%0d mode=%0d temp=%0d fan=%0d csum=%h rsum=%h ok=%0d pad=%h",
                        a.is_match, a.power_state, a.op_mode, a.temperature,
                        a.fan_speed, a.computed_sum, a.received_sum, a.sum_ok, pad);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] frame_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [0] is_match, [2:1] power_state, [5:3] op_mode,
                             // [14:6] temperature, [17:15] fan_speed,
                             // [21:18] computed_sum, [25:22] received_sum, [26] sum_ok

   frame_scoreboard frames = new();
   logic [7:0]      frame_bytes[$];
   int              bytes_sent = 0;
   int              cycle_count = 0;
   bit              quiet = 1'b0;
   bit              hold_req = 1'b0;

   ac_ir_frame_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("ac_ir_frame_decoder_unit_tb: done, errors");
      $finish;
   end

   // result side: random back-pressure plus one long hold-off
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // outputs are stable at the falling edge, ahead of the transfer edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) frames.check_result(rsp_tdata);
   end

   // offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      frames.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // well-formed 13-byte frame with a good or bad checksum nibble
   function automatic void build_frame(input logic [7:0] temp, input logic [7:0] power,
                                       input logic [7:0] mode_fan, input bit sum_good);
      logic [7:0] acc;
      logic [7:0] sum_b;
      logic [3:0] fold;
      frame_bytes.delete();
      frame_bytes.push_back(HDR0);
      frame_bytes.push_back(HDR1);
      frame_bytes.push_back(HDR2);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(temp);
      frame_bytes.push_back(power);
      frame_bytes.push_back(mode_fan);
      repeat (5) frame_bytes.push_back(8'($urandom));
      acc = '0;
      foreach (frame_bytes[i]) acc = acc ^ frame_bytes[i];
      sum_b[3:0] = 4'($urandom);
      acc        = acc ^ {4'h0, sum_b[3:0]};
      fold       = acc[7:4] ^ acc[3:0];
      sum_b[7:4] = sum_good ? fold : fold ^ 4'($urandom_range(1, 15));
      frame_bytes.push_back(sum_b);
   endfunction

   // random frame content biased toward the decoded codes
   function automatic void build_random_frame();
      logic [7:0] temp;
      logic [7:0] power;
      logic [3:0] mode_nib;
      logic [3:0] fan_nib;
      temp = ($urandom_range(6) == 0) ? 8'd0 : 8'($urandom);
      case ($urandom_range(2))
         0:       power = PWR_OFF_BYTE;
         1:       power = PWR_ON_BYTE;
         default: power = 8'($urandom);
      endcase
      case ($urandom_range(3))
         0:       mode_nib = MODE_NIB_HEAT;
         1:       mode_nib = MODE_NIB_COOL;
         2:       mode_nib = MODE_NIB_DRY;
         default: mode_nib = 4'($urandom);
      endcase
      case ($urandom_range(4))
         0:       fan_nib = FAN_NIB_AUTO;
         1:       fan_nib = FAN_NIB_S1;
         2:       fan_nib = FAN_NIB_S2;
         3:       fan_nib = FAN_NIB_S3;
         default: fan_nib = 4'($urandom);
      endcase
      build_frame(temp, power, {fan_nib, mode_nib}, $urandom_range(1));
   endfunction

   initial begin : req_side
      int kind;
      int len;
      int frame_no;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: decoded codes, extremes of temperature, checksum good and bad
      build_frame(8'h00, PWR_OFF_BYTE, {FAN_NIB_AUTO, MODE_NIB_HEAT}, 1'b1);
      send_frame();
      build_frame(8'hFF, PWR_ON_BYTE, {FAN_NIB_S1, MODE_NIB_COOL}, 1'b0);
      send_frame();
      build_frame(8'h05, 8'h00, {FAN_NIB_S2, MODE_NIB_DRY}, 1'b1);
      send_frame();
      build_frame(8'h08, 8'hFF, {FAN_NIB_S3, MODE_NIB_HEAT}, 1'b1);
      send_frame();
      build_frame(8'h01, 8'h20, 8'hF4, 1'b0);
      send_frame();

      // directed: each header byte wrong in turn
      for (int p = 0; p < 3; p++) begin
         build_frame(8'h10, PWR_ON_BYTE, {FAN_NIB_AUTO, MODE_NIB_COOL}, 1'b1);
         frame_bytes[p] = ~frame_bytes[p];
         send_frame();
      end

      // directed: short, one byte long, over-long and saturated frames
      build_frame(8'h10, PWR_ON_BYTE, {FAN_NIB_AUTO, MODE_NIB_COOL}, 1'b1);
      void'(frame_bytes.pop_back());
      send_frame();
      send_byte(HDR0, 1'b1);
      build_frame(8'h10, PWR_ON_BYTE, {FAN_NIB_AUTO, MODE_NIB_COOL}, 1'b1);
      frame_bytes.push_back(8'hFF);
      send_frame();
      build_frame(8'h10, PWR_ON_BYTE, {FAN_NIB_AUTO, MODE_NIB_COOL}, 1'b1);
      repeat (7) frame_bytes.push_back(8'($urandom));
      send_frame();

      // random: mostly well-formed frames, some broken, some noise
      frame_no = 0;
      while (bytes_sent < BYTE_TARGET) begin
         frame_no++;
         if (frame_no == 20) hold_req = 1'b1;
         quiet = (frame_no >= 50 && frame_no < 70);
         kind = $urandom_range(99);
         if (kind < 75) begin
            build_random_frame();
         end else if (kind < 85) begin
            // corrupt one header byte
            build_random_frame();
            len = $urandom_range(2);
            frame_bytes[len] = frame_bytes[len] ^ 8'($urandom_range(1, 255));
         end else if (kind < 95) begin
            // right header, wrong length
            build_random_frame();
            if ($urandom_range(1)) begin
               len = $urandom_range(1, 12);
               while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
            end else begin
               len = $urandom_range(14, 20);
               while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
            end
         end else begin
            // line noise
            frame_bytes.delete();
            len = $urandom_range(1, 16);
            repeat (len) frame_bytes.push_back(8'($urandom));
         end
         send_frame();
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      // drain the owed results, then let the output register settle
      while (frames.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.errors == 0 && frames.owed.size() == 0) begin
         $display("ac_ir_frame_decoder_unit_tb: done, clean");
      end else begin
         $display("ac_ir_frame_decoder_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
